>>> rtl/core/hss_pkg.sv
// Shared types and constants for the heat stencil sweep block.
`default_nettype none

package hss_pkg;

  // Default line buffer depth and output queue depth.
  localparam int LINE_DEPTH_DEF = 1024;
  localparam int FIFO_DEPTH_DEF = 16;

  localparam int DATA_W = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_CENTRE_GAIN    = 3'd0;
  localparam logic [2:0] REG_NEIGHBOUR_GAIN = 3'd1;
  localparam logic [2:0] REG_TIME_STEP      = 3'd2;
  localparam logic [2:0] REG_GRID_WIDTH     = 3'd3;
  localparam logic [2:0] REG_GRID_HEIGHT    = 3'd4;

  // Control that travels with an item through the arithmetic pipeline.
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } hss_ctrl_t;

  // One finished result.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } hss_result_t;

endpackage

`default_nettype wire

>>> rtl/core/hss_line_buffer.sv
// Single-port-write, single-port-read line buffer with registered read data.
`default_nettype none

module hss_line_buffer #(
  parameter int DEPTH = hss_pkg::LINE_DEPTH_DEF,
  parameter int WIDTH = hss_pkg::DATA_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hss_tap_cell.sv
// One cell of the stencil window: a tap that takes its neighbor's value on each shift.
`default_nettype none

module hss_tap_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      shift_en,
  input  wire logic [hss_pkg::DATA_W-1:0] tap_in,
  output logic      [hss_pkg::DATA_W-1:0] tap_out
);

  logic [hss_pkg::DATA_W-1:0] tap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
    end else if (shift_en) begin
      tap_r <= tap_in;
    end
  end

  assign tap_out = tap_r;

endmodule

`default_nettype wire

>>> rtl/core/hss_stencil_mac.sv
// Pipelined stencil arithmetic: neighbor sum, three products, rounding and saturation.
`default_nettype none

module hss_stencil_mac (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic signed [31:0]           centre_gain,
  input  wire logic signed [31:0]           neighbour_gain,
  input  wire logic signed [31:0]           time_step,
  input  wire hss_pkg::hss_ctrl_t           ctrl_in,
  input  wire logic signed [31:0]           tap_w,
  input  wire logic signed [31:0]           tap_c,
  input  wire logic signed [31:0]           tap_e,
  input  wire logic signed [31:0]           north,
  input  wire logic signed [31:0]           south,
  input  wire logic signed [31:0]           source,
  output hss_pkg::hss_ctrl_t                ctrl_out,
  output hss_pkg::hss_result_t              result
);

  localparam logic signed [66:0] ROUND_HALF = 67'sd8388608;

  hss_pkg::hss_ctrl_t ctrl_a_r, ctrl_b_r, ctrl_c_r, ctrl_d_r;

  logic signed [33:0] nsum_r;
  logic signed [31:0] centre_r;
  logic signed [31:0] source_r;
  logic signed [63:0] p_centre_r;
  logic signed [65:0] p_neigh_r;
  logic signed [63:0] p_source_r;
  logic signed [66:0] partial_r;
  logic signed [63:0] p_source_d_r;
  logic signed [66:0] total_r;

  logic signed [42:0] quot;
  logic               in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_a_r <= '0;
      ctrl_b_r <= '0;
      ctrl_c_r <= '0;
      ctrl_d_r <= '0;
    end else begin
      ctrl_a_r <= ctrl_in;
      ctrl_b_r <= ctrl_a_r;
      ctrl_c_r <= ctrl_b_r;
      ctrl_d_r <= ctrl_c_r;
    end
  end

  always_ff @(posedge clk) begin
    nsum_r       <= 34'(tap_w) + 34'(tap_e) + 34'(north) + 34'(south);
    centre_r     <= tap_c;
    source_r     <= source;
    p_centre_r   <= 64'(centre_gain) * 64'(centre_r);
    p_neigh_r    <= 66'(neighbour_gain) * 66'(nsum_r);
    p_source_r   <= 64'(time_step) * 64'(source_r);
    partial_r    <= 67'(p_centre_r) + 67'(p_neigh_r);
    p_source_d_r <= p_source_r;
    total_r      <= partial_r + 67'(p_source_d_r) + ROUND_HALF;
  end

  // Round to nearest with ties upward was folded into the add; drop the fraction.
  assign quot     = total_r[66:24];
  assign in_range = (&quot[42:31]) | ~(|quot[42:31]);

  always_comb begin
    if (in_range) begin
      result.value = quot[31:0];
    end else if (quot[42]) begin
      result.value = 32'h8000_0000;
    end else begin
      result.value = 32'h7fff_ffff;
    end
    result.last = ctrl_d_r.last;
  end

  assign ctrl_out = ctrl_d_r;

endmodule

`default_nettype wire

>>> rtl/core/hss_out_fifo.sv
// Small output queue that decouples the pipeline from the result receiver.
`default_nettype none

module hss_out_fifo #(
  parameter int DEPTH = hss_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire hss_pkg::hss_result_t wr_data,
  input  wire logic                 rd_en,
  output hss_pkg::hss_result_t      rd_data,
  output logic                      not_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  hss_pkg::hss_result_t entry_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      count_r <= count_r + CNTW'(wr_en) - CNTW'(rd_en);
    end
  end

  assign rd_data   = entry_r[rd_ptr_r];
  assign not_empty = (count_r != '0);

endmodule

`default_nettype wire

>>> rtl/core/heat_stencil_sweep.sv
// Top level of the heat stencil sweep: one explicit time step of the 2D heat equation.
//
// The padded old grid (interior plus a one-point halo on every side) streams in on the
// in_ channel in raster order, one item per point carrying the old value and the source
// term. For every interior point the block emits one item on the out_ channel:
// centre_gain*C + neighbour_gain*(N+S+E+W) + time_step*source in signed Q8.24, rounded
// to nearest and saturated to 32 bits; out_tlast marks the last interior point.
// A result leaves once the point's south neighbor has been accepted.
// Throughput is one item per cycle while in_tready is high. After the south neighbor
// is accepted, the line buffers are read at the accepting edge, then the window shifts,
// the item passes through the arithmetic pipeline and its result is written to the
// output queue, which raises out_tvalid.
// A queue of FIFO_DEPTH results absorbs receiver stalls; in_tready falls only when every
// queue slot is claimed by items already in flight, so nothing is ever dropped.
// Reset (rst_n low at a clock edge) clears the counters, the window, the pipeline and
// the queue and sets the registers to their defaults; the line buffers keep their data,
// which is always rewritten before it is read within a pass. Registers must be written
// over the cfg_ port only while idle (unenforced); geometry applies from the next item.
`default_nettype none

module heat_stencil_sweep #(
  parameter int LINE_DEPTH = hss_pkg::LINE_DEPTH_DEF,
  parameter int FIFO_DEPTH = hss_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input items.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] old_value, [63:32] source_value
  // Result items.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] new_value
  output logic             out_tlast,  // last_point
  // Register port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CW   = $clog2(LINE_DEPTH);
  localparam int XW   = (CW > 10) ? CW : 10;
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);
  localparam logic [XW-1:0] W_MAX = XW'(LINE_DEPTH - 2);

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] centre_gain_r, neighbour_gain_r, time_step_r;
  logic [9:0]         grid_width_r;
  logic [15:0]        grid_height_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_gain_r    <= '0;
      neighbour_gain_r <= '0;
      time_step_r      <= '0;
      grid_width_r     <= 10'd1;
      grid_height_r    <= 16'd1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        hss_pkg::REG_CENTRE_GAIN:    centre_gain_r    <= cfg_pwdata;
        hss_pkg::REG_NEIGHBOUR_GAIN: neighbour_gain_r <= cfg_pwdata;
        hss_pkg::REG_TIME_STEP:      time_step_r      <= cfg_pwdata;
        hss_pkg::REG_GRID_WIDTH:     grid_width_r     <= cfg_pwdata[9:0];
        hss_pkg::REG_GRID_HEIGHT:    grid_height_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      hss_pkg::REG_CENTRE_GAIN:    cfg_prdata = centre_gain_r;
      hss_pkg::REG_NEIGHBOUR_GAIN: cfg_prdata = neighbour_gain_r;
      hss_pkg::REG_TIME_STEP:      cfg_prdata = time_step_r;
      hss_pkg::REG_GRID_WIDTH:     cfg_prdata = {22'd0, grid_width_r};
      hss_pkg::REG_GRID_HEIGHT:    cfg_prdata = {16'd0, grid_height_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Geometry and raster position
  // ---------------------------------------------------------------------------
  // Width is clamped to 1..LINE_DEPTH-2 and height to at least 1.
  logic [XW-1:0] width_x, width_eff_x;
  logic [CW-1:0] width_eff, col_end;
  logic [15:0]   height_eff;
  logic [16:0]   row_end;

  assign width_x = XW'(grid_width_r);

  always_comb begin
    if (grid_width_r == '0) begin
      width_eff_x = XW'(1);
    end else if (width_x > W_MAX) begin
      width_eff_x = W_MAX;
    end else begin
      width_eff_x = width_x;
    end
  end

  assign width_eff  = width_eff_x[CW-1:0];
  assign col_end    = width_eff + CW'(1);
  assign height_eff = (grid_height_r == '0) ? 16'd1 : grid_height_r;
  assign row_end    = {1'b0, height_eff} + 17'd1;

  logic [CW-1:0] col_r;
  logic [16:0]   row_r;
  logic          accept, col_wrap, emit_now, last_now;
  logic [CW-1:0] prev_raddr;

  assign accept   = in_tvalid & in_tready;
  assign col_wrap = (col_r >= col_end);
  // The item at (row, col) is the south neighbor of interior point (row-1, col).
  assign emit_now = (row_r >= 17'd2) && (row_r <= row_end) &&
                    (col_r != '0) && (col_r <= width_eff);
  assign last_now = (col_r == width_eff) && (row_r == row_end);

  // The window's east tap wants the row above at col+1. On the row's closing item
  // that slot is unused, so it fetches column 0, the first west tap of the next row.
  assign prev_raddr = col_wrap ? '0 : col_r + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_r <= '0;
        row_r <= (row_r >= row_end) ? '0 : row_r + 17'd1;
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line buffer reads are in flight; the item waits beside them.
  // ---------------------------------------------------------------------------
  logic          s1_valid_r, s1_emit_r, s1_last_r;
  logic [CW-1:0] s1_col_r;
  logic [31:0]   s1_cur_r, s1_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r  <= col_r;
      s1_cur_r  <= in_tdata[31:0];
      s1_src_r  <= in_tdata[63:32];
      s1_emit_r <= emit_now;
      s1_last_r <= last_now;
    end
  end

  logic [31:0] prev_rdata, older_rdata, source_rdata;
  logic [31:0] tap_w, tap_c, tap_e;

  // Row above: old values of the current row are written as they pass.
  hss_line_buffer #(.DEPTH(LINE_DEPTH), .WIDTH(32), .AW(CW)) u_prev_row (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (s1_cur_r),
    .re    (accept),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  // Two rows up: the east tap about to become the centre is exactly the value the
  // row above held at this column, so it moves down one row from there.
  hss_line_buffer #(.DEPTH(LINE_DEPTH), .WIDTH(32), .AW(CW)) u_older_row (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (tap_e),
    .re    (accept),
    .raddr (col_r),
    .rdata (older_rdata)
  );

  // Source terms of the row above, which holds the centre points.
  hss_line_buffer #(.DEPTH(LINE_DEPTH), .WIDTH(32), .AW(CW)) u_source_row (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (s1_src_r),
    .re    (accept),
    .raddr (col_r),
    .rdata (source_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: the three-cell window over the row above shifts once per item.
  // ---------------------------------------------------------------------------
  hss_tap_cell u_tap_e (
    .clk (clk), .rst_n (rst_n), .shift_en (s1_valid_r), .tap_in (prev_rdata), .tap_out (tap_e)
  );
  hss_tap_cell u_tap_c (
    .clk (clk), .rst_n (rst_n), .shift_en (s1_valid_r), .tap_in (tap_e), .tap_out (tap_c)
  );
  hss_tap_cell u_tap_w (
    .clk (clk), .rst_n (rst_n), .shift_en (s1_valid_r), .tap_in (tap_c), .tap_out (tap_w)
  );

  hss_pkg::hss_ctrl_t s2_ctrl_r;
  logic [31:0]        s2_north_r, s2_south_r, s2_src_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctrl_r <= '0;
    end else begin
      s2_ctrl_r.valid <= s1_valid_r;
      s2_ctrl_r.emit  <= s1_emit_r;
      s2_ctrl_r.last  <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_north_r <= older_rdata;
      s2_south_r <= s1_cur_r;
      s2_src_r   <= source_rdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Arithmetic and output queue
  // ---------------------------------------------------------------------------
  hss_pkg::hss_ctrl_t   done_ctrl;
  hss_pkg::hss_result_t done_result, head;

  hss_stencil_mac u_mac (
    .clk            (clk),
    .rst_n          (rst_n),
    .centre_gain    (centre_gain_r),
    .neighbour_gain (neighbour_gain_r),
    .time_step      (time_step_r),
    .ctrl_in        (s2_ctrl_r),
    .tap_w          (tap_w),
    .tap_c          (tap_c),
    .tap_e          (tap_e),
    .north          (s2_north_r),
    .south          (s2_south_r),
    .source         (s2_src_r),
    .ctrl_out       (done_ctrl),
    .result         (done_result)
  );

  logic fifo_wr, fifo_rd;

  assign fifo_wr = done_ctrl.valid & done_ctrl.emit;
  assign fifo_rd = out_tvalid & out_tready;

  hss_out_fifo #(.DEPTH(FIFO_DEPTH)) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (fifo_wr),
    .wr_data   (done_result),
    .rd_en     (fifo_rd),
    .rd_data   (head),
    .not_empty (out_tvalid)
  );

  assign out_tdata = head.value;
  assign out_tlast = head.last;

  // Every accepted item claims a queue slot; it is released when the item leaves the
  // pipeline without a result, or when its result is taken from the queue.
  logic [CNTW-1:0] credit_r;
  logic            drop;

  assign drop      = done_ctrl.valid & ~done_ctrl.emit;
  assign in_tready = (credit_r < CNTW'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_r + CNTW'(accept) - CNTW'(drop) - CNTW'(fifo_rd);
    end
  end

`ifndef SYNTHESIS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CNTW'(FIFO_DEPTH))
    else $error("slot count exceeds queue depth");

  a_result_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> credit_r != '0)
    else $error("result queued without a claimed slot");

  a_last_is_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_now) |-> emit_now)
    else $error("last point flagged on an item without a result");

  a_col_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && col_wrap) |=> col_r == '0)
    else $error("column counter did not wrap at row end");

  a_stage1_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted item missing from stage 1");
`endif

endmodule

`default_nettype wire
